FILE: sv/mfp_pkg.sv
// Shared types, constants and helper functions for the message frame packer.
// No dependencies; imported by the front end, queue, back end and top level.
package mfp_pkg;

    localparam int DataW      = 8;
    localparam int LenW       = 16;
    localparam int RemW       = 14;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 8;
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCntW      = $clog2(QueueDepth + 1);

    localparam logic [DataW-1:0] LrcInit   = 8'hFF;
    localparam logic [DataW-1:0] AsciiZero = 8'h30;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_PACK_MODE = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_START     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_END       = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ATTR      = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_CMD       = 3'd4;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_LRC  = 2'd1,
        MODE_STX  = 2'd2,
        MODE_DEC  = 2'd3
    } mode_t;

    // Framing characters used by the back end
    typedef struct packed {
        logic [DataW-1:0] start_byte;
        logic [DataW-1:0] end_byte;
        logic [DataW-1:0] attribute_byte;
        logic [DataW-1:0] command_byte;
    } cfg_t;

    // One classified input beat as it sits in the queue
    typedef struct packed {
        logic [DataW-1:0] data;
        logic             first;
        logic             last;
        mode_t            mode;
        logic [LenW-1:0]  len;
        logic [RemW-1:0]  rem;   // length modulo 10000
    } item_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

    // Length modulo 10000: six parallel compares and one subtract
    function automatic logic [RemW-1:0] mod_10k(input logic [LenW-1:0] len);
        logic [2:0] q;
        q = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (len >= LenW'(k * 10000)) q = 3'(k);
        end
        return RemW'(len - LenW'(q) * LenW'(10000));
    endfunction

    // Weight of a decimal position, most significant first
    function automatic logic [9:0] scale_of(input logic [1:0] pos);
        logic [9:0] s;
        case (pos)
            2'd0:    s = 10'd1000;
            2'd1:    s = 10'd100;
            2'd2:    s = 10'd10;
            default: s = 10'd1;
        endcase
        return s;
    endfunction

    // Decimal digit at a position: nine parallel compares
    function automatic logic [3:0] digit_of(input logic [RemW-1:0] r, input logic [1:0] pos);
        logic [3:0]      d;
        logic [RemW-1:0] s;
        d = 4'd0;
        s = RemW'(scale_of(pos));
        for (int k = 1; k <= 9; k++) begin
            if (r >= RemW'(k) * s) d = 4'(k);
        end
        return d;
    endfunction

endpackage

FILE: sv/mfp_front.sv
// Front end: configuration registers and classification of input beats.
// Depends on mfp_pkg; feeds mfp_queue.
module mfp_front import mfp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  q_status_t           q_status,
    output logic                push,
    output item_t               push_item,
    output cfg_t                cfg
);

    mode_t            pack_mode_reg;
    logic [DataW-1:0] start_reg;
    logic [DataW-1:0] end_reg;
    logic [DataW-1:0] attr_reg;
    logic [DataW-1:0] cmd_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pack_mode_reg <= MODE_NONE;
            start_reg     <= 8'h02;
            end_reg       <= 8'h03;
            attr_reg      <= 8'h00;
            cmd_reg       <= 8'h00;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PACK_MODE: pack_mode_reg <= mode_t'(cfg_wdata[1:0]);
                REG_START:     start_reg     <= cfg_wdata;
                REG_END:       end_reg       <= cfg_wdata;
                REG_ATTR:      attr_reg      <= cfg_wdata;
                REG_CMD:       cmd_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.start_byte     = start_reg;
    assign cfg.end_byte       = end_reg;
    assign cfg.attribute_byte = attr_reg;
    assign cfg.command_byte   = cmd_reg;

    // Accept while the queue has room
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && s_tready;

    // Classify the beat: tag with mode, reduce the length for decimal framing
    always_comb begin
        push_item.data  = s_tdata[7:0];
        push_item.first = s_tuser;
        push_item.last  = s_tlast;
        push_item.mode  = pack_mode_reg;
        push_item.len   = s_tdata[23:8];
        push_item.rem   = mod_10k(s_tdata[23:8]);
    end

endmodule

FILE: sv/mfp_queue.sv
// Short queue of classified beats between front and back end.
// Depends on mfp_pkg.
module mfp_queue import mfp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  item_t     push_item,
    input  logic      pop,
    output item_t     head,
    output q_status_t q_status
);

    item_t            mem [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QCntW-1:0] count_reg;

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign head                = mem[rd_ptr_reg];
    assign q_status.full       = (count_reg == QCntW'(QueueDepth));
    assign q_status.head_valid = (count_reg != '0);

endmodule

FILE: sv/mfp_back.sv
// Back end: sequences header, data and trailer bytes of the queue head
// into the output register. Depends on mfp_pkg.
module mfp_back import mfp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  item_t            head,
    input  logic             head_valid,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [DataW-1:0] m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        ST_START,
        ST_HEAD,
        ST_DATA,
        ST_END,
        ST_CHECK
    } state_t;

    state_t           state_reg;
    state_t           eff_state;
    state_t           state_next;
    logic [2:0]       idx_reg;
    logic [2:0]       idx_next;
    logic [2:0]       idx_m1;
    logic [2:0]       last_idx;
    logic [DataW-1:0] chk_reg;
    logic [DataW-1:0] chk_next;
    logic [RemW-1:0]  rem_reg;
    logic [RemW-1:0]  rem_next;
    logic [1:0]       pos;
    logic [3:0]       digit;
    logic [DataW-1:0] digit_char;
    logic [DataW-1:0] out_byte;
    logic             final_byte;
    logic             adv;
    logic             m_valid_reg;
    logic [DataW-1:0] m_data_reg;
    logic             m_run_reg;
    logic             m_frame_reg;

    // Current decimal digit of the working remainder
    assign idx_m1     = idx_reg - 3'd1;
    assign pos        = idx_m1[1:0];
    assign digit      = digit_of(rem_reg, pos);
    assign digit_char = AsciiZero + {4'd0, digit};
    assign last_idx   = (head.mode == MODE_STX) ? 3'd0 : 3'd4;

    // Move a byte whenever the queue has a head and the output register is free or being drained
    assign adv = head_valid && (!m_valid_reg || m_tready);
    assign pop = adv && final_byte;

    // Pick the byte for this step and the next sequencer state
    always_comb begin
        if (state_reg == ST_START) begin
            eff_state = (head.first && head.mode != MODE_NONE) ? ST_HEAD : ST_DATA;
        end else begin
            eff_state = state_reg;
        end

        out_byte   = head.data;
        chk_next   = chk_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        state_next = eff_state;
        final_byte = 1'b0;

        unique case (eff_state)
            ST_HEAD: begin
                idx_next   = idx_reg + 3'd1;
                state_next = (idx_reg == last_idx) ? ST_DATA : ST_HEAD;
                if (idx_reg == 3'd0) begin
                    out_byte = cfg.start_byte;
                    rem_next = head.rem;
                    chk_next = (head.mode == MODE_LRC)
                             ? (LrcInit ^ head.len[15:8] ^ head.len[7:0] ^ cfg.command_byte)
                             : 8'h00;
                end else if (head.mode == MODE_LRC) begin
                    case (idx_reg)
                        3'd1:    out_byte = cfg.attribute_byte;
                        3'd2:    out_byte = head.len[15:8];
                        3'd3:    out_byte = head.len[7:0];
                        default: out_byte = cfg.command_byte;
                    endcase
                end else begin
                    out_byte = digit_char;
                    chk_next = chk_reg ^ digit_char;
                    rem_next = rem_reg - RemW'(digit) * RemW'(scale_of(pos));
                end
            end
            ST_DATA: begin
                out_byte   = head.data;
                chk_next   = (head.mode != MODE_NONE) ? (chk_reg ^ head.data) : chk_reg;
                final_byte = !(head.last && head.mode != MODE_NONE);
                state_next = (head.mode == MODE_LRC) ? ST_CHECK : ST_END;
            end
            ST_END: begin
                out_byte   = cfg.end_byte;
                chk_next   = chk_reg ^ cfg.end_byte;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                out_byte   = chk_reg;
                chk_next   = 8'h00;
                final_byte = 1'b1;
            end
            default: begin
                out_byte = head.data;
            end
        endcase
    end

    // Hold sequencer state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_START;
            idx_reg     <= 3'd0;
            chk_reg     <= 8'h00;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            state_reg   <= final_byte ? ST_START : state_next;
            idx_reg     <= final_byte ? 3'd0 : idx_next;
            chk_reg     <= chk_next;
            rem_reg     <= rem_next;
            m_valid_reg <= 1'b1;
            m_data_reg  <= out_byte;
            m_run_reg   <= final_byte;
            m_frame_reg <= final_byte && head.last;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_run_reg;
    assign m_tlast  = m_frame_reg;

endmodule

FILE: sv/message_frame_packer_unit.sv
// Top level of the message frame packer: front end, queue, back end.
// Depends on mfp_pkg, mfp_front, mfp_queue and mfp_back.
//
//  channel  | direction | tdata                          | tuser            | tlast
//  ---------+-----------+--------------------------------+------------------+---------------
//  s_       | in        | [7:0] data_byte, [23:8] length | first_of_message | last_of_message
//  m_       | out       | [7:0] out_byte                 | end_of_run       | end_of_frame
//  cfg_     | in        | write: index 0..4, 8-bit data  | -                | -
//
// The output stream moves one beat per cycle unless m_tready is low, which
// holds the output beat, or the queue is empty. The back-end sequencer makes 1
// output byte per input beat in mode 0 and up to 8 (5 header, data, 2 trailer)
// in the framed modes. A 4-entry queue lets input beats keep arriving while a
// header or trailer goes out. Reset (aresetn low, synchronous) empties the queue
// and output register and restores register defaults. A full queue drops s_tready.
module message_frame_packer_unit import mfp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // [7:0] data_byte, [23:8] message_length
    input  logic                s_tuser,   // [0] first_of_message
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic                m_tuser,   // [0] end_of_run
    output logic                m_tlast
);

    cfg_t      cfg;
    item_t     push_item;
    item_t     head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    mfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item),
        .cfg       (cfg)
    );

    mfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    mfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .head       (head),
        .head_valid (q_status.head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: sv/mfp_checker.sv
// Port-level checks for the message frame packer, bound to the top level.
// Depends on message_frame_packer_unit.
module mfp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // End of frame is always the end of a run
    a_frame_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("end of frame without end of run");

    // A taken beat that does not close its run is followed at once by the next
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid)
        else $error("gap inside a run");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind message_frame_packer_unit mfp_checker u_mfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: bench/tb_message_frame_packer_unit.sv
// Self-checking bench for message_frame_packer_unit: streams message bytes through every
// framing mode and compares each framed output beat against an in-bench frame predictor.
// Depends on mfp_pkg and the message_frame_packer_unit RTL.
module tb_message_frame_packer_unit;
    import mfp_pkg::*;

    // One message byte as offered on the input channel
    typedef struct packed {
        logic [DataW-1:0] data;
        logic             first;
        logic             last;
        logic [LenW-1:0]  len;
    } msg_item_t;

    // One byte of the framed stream with its markers
    typedef struct packed {
        logic [DataW-1:0] out_byte;
        logic             run_end;
        logic             frame_end;
    } framed_beat_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // Predictor copy of the registers and the running check
    mode_t            pred_mode   = MODE_NONE;
    logic [DataW-1:0] pred_start  = 8'h02;
    logic [DataW-1:0] pred_end    = 8'h03;
    logic [DataW-1:0] pred_attr   = 8'h00;
    logic [DataW-1:0] pred_cmd    = 8'h00;
    logic [DataW-1:0] frame_check = 8'h00;

    msg_item_t    pending_items[$];
    framed_beat_t frame_expect[$];
    framed_beat_t run_beats[8];
    int           run_len;
    msg_item_t    drive_item;
    framed_beat_t want_beat;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_armed = 1'b0;
    logic hold_taken = 1'b0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  beats_seen = 0;

    message_frame_packer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: beat %0d: %s: got 0x%0h, expected 0x%0h",
                 $time, beats_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void stage_byte(input logic [DataW-1:0] b);
        run_beats[run_len] = '{b, 1'b0, 1'b0};
        run_len++;
    endfunction

    // Work out the framed bytes caused by one accepted message byte
    task automatic predict_frame(input logic [DataW-1:0] data, input logic first,
                                 input logic last, input logic [LenW-1:0] len);
        int               rem;
        int               weight;
        logic [DataW-1:0] digit;
        logic [DataW-1:0] acc;
        run_len = 0;
        if (first) begin
            case (pred_mode)
                MODE_LRC: begin
                    stage_byte(pred_start);
                    stage_byte(pred_attr);
                    stage_byte(len[15:8]);
                    stage_byte(len[7:0]);
                    stage_byte(pred_cmd);
                    frame_check = LrcInit ^ len[15:8] ^ len[7:0] ^ pred_cmd;
                end
                MODE_STX: begin
                    stage_byte(pred_start);
                    frame_check = 8'h00;
                end
                MODE_DEC: begin
                    stage_byte(pred_start);
                    rem = int'(len) % 10000;
                    weight = 1000;
                    acc = 8'h00;
                    for (int k = 0; k < 4; k++) begin
                        digit = AsciiZero + 8'((rem / weight) % 10);
                        stage_byte(digit);
                        acc ^= digit;
                        weight /= 10;
                    end
                    frame_check = acc;
                end
                default: ;
            endcase
        end
        stage_byte(data);
        if (pred_mode != MODE_NONE) frame_check ^= data;
        if (last) begin
            case (pred_mode)
                MODE_LRC: begin
                    stage_byte(frame_check);
                    frame_check = 8'h00;
                end
                MODE_STX, MODE_DEC: begin
                    stage_byte(pred_end);
                    frame_check ^= pred_end;
                    stage_byte(frame_check);
                    frame_check = 8'h00;
                end
                default: ;
            endcase
            run_beats[run_len-1].frame_end = 1'b1;
        end
        run_beats[run_len-1].run_end = 1'b1;
        for (int k = 0; k < run_len; k++) frame_expect.push_back(run_beats[k]);
    endtask

    // Driver: advance to the next pending byte once the current beat is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drive_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {drive_item.len, drive_item.data};
                s_tuser  <= drive_item.first;
                s_tlast  <= drive_item.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_armed && !hold_taken) begin
            hold_left  <= 400;
            hold_taken <= 1'b1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on input beats first, then check the output beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_frame(s_tdata[7:0], s_tuser, s_tlast, s_tdata[23:8]);
            end
            if (m_tvalid && m_tready) begin
                if (frame_expect.size() == 0) begin
                    report_mismatch("output beat with nothing expected", m_tdata, 0);
                end else begin
                    want_beat = frame_expect.pop_front();
                    if (m_tdata !== want_beat.out_byte)
                        report_mismatch("out_byte", m_tdata, want_beat.out_byte);
                    if (m_tuser !== want_beat.run_end)
                        report_mismatch("end_of_run", m_tuser, want_beat.run_end);
                    if (m_tlast !== want_beat.frame_end)
                        report_mismatch("end_of_frame", m_tlast, want_beat.frame_end);
                end
                beats_seen++;
            end
        end
    end

    // Register write while idle; the predictor copy follows it
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PACK_MODE: pred_mode  = mode_t'(val[1:0]);
            REG_START:     pred_start = val;
            REG_END:       pred_end   = val;
            REG_ATTR:      pred_attr  = val;
            REG_CMD:       pred_cmd   = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic push_item(input logic [DataW-1:0] data, input logic first,
                             input logic last, input logic [LenW-1:0] len);
        pending_items.push_back('{data, first, last, len});
    endtask

    // Hold until every byte is sent and every framed byte has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || frame_expect.size() != 0)
            @(negedge aclk);
    endtask

    // Header length: mostly the true count, sometimes a mismatch or a decimal edge
    function automatic logic [LenW-1:0] pick_length(input int msg_len);
        logic [LenW-1:0] picked;
        case ($urandom_range(0, 9))
            6: picked = 16'($urandom);
            7: begin
                case ($urandom_range(0, 3))
                    0: picked = 16'd9999;
                    1: picked = 16'd10000;
                    2: picked = 16'hFFFF;
                    default: picked = 16'd1;
                endcase
            end
            8: picked = 16'($urandom_range(10000, 65535));
            9: picked = 16'($urandom_range(1, 9999));
            default: picked = 16'(msg_len);
        endcase
        return picked;
    endfunction

    // Mostly whole messages with random content, some truncated ones and stray bytes
    task automatic queue_traffic(input int count);
        int              sent;
        int              msg_len;
        logic            truncated;
        logic [LenW-1:0] len_field;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(1, 6);
                truncated = ($urandom_range(0, 7) == 0);
                len_field = pick_length(msg_len);
                for (int k = 0; k < msg_len; k++) begin
                    push_item(8'($urandom), k == 0, (k == msg_len - 1) && !truncated,
                              (k == 0) ? len_field : 16'($urandom));
                end
                sent += msg_len;
            end else begin
                push_item(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
                sent++;
            end
        end
    endtask

    // Ends a hung run
    initial begin
        #(12 * 400000);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int p;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: plain pass-through, last byte closes the frame
        push_item(8'h00, 1'b1, 1'b0, 16'd1);
        push_item(8'hFF, 1'b0, 1'b1, 16'hFFFF);
        wait_drained();

        // Binary header with LRC, extreme framing characters
        write_reg(REG_PACK_MODE, 8'(MODE_LRC));
        write_reg(REG_START, 8'hFF);
        write_reg(REG_ATTR, 8'h00);
        write_reg(REG_CMD, 8'hFF);
        push_item(8'h55, 1'b1, 1'b1, 16'd0);       // zero length header
        push_item(8'h00, 1'b1, 1'b0, 16'hFFFF);    // header count disagrees with data
        push_item(8'hFF, 1'b0, 1'b1, 16'd0);
        push_item(8'hAA, 1'b0, 1'b0, 16'd1234);    // stray byte, no open frame
        push_item(8'h11, 1'b1, 1'b0, 16'd3);
        push_item(8'h22, 1'b1, 1'b0, 16'd2);       // restart inside an open message
        push_item(8'h33, 1'b0, 1'b1, 16'd0);
        wait_drained();

        // Start/end framing with XOR check
        write_reg(REG_PACK_MODE, 8'(MODE_STX));
        write_reg(REG_START, 8'h00);
        write_reg(REG_END, 8'hFF);
        write_reg(REG_ATTR, 8'hFF);
        write_reg(REG_CMD, 8'h00);
        push_item(8'h80, 1'b1, 1'b0, 16'd5);
        push_item(8'h01, 1'b0, 1'b0, 16'd0);
        push_item(8'h7F, 1'b0, 1'b1, 16'd0);
        push_item(8'hFE, 1'b1, 1'b1, 16'd1);
        wait_drained();

        // Decimal length digits around the modulo wrap
        write_reg(REG_PACK_MODE, 8'(MODE_DEC));
        write_reg(REG_START, 8'h7E);
        write_reg(REG_END, 8'h0D);
        push_item(8'h12, 1'b1, 1'b1, 16'd9999);
        push_item(8'h34, 1'b1, 1'b1, 16'd10000);
        push_item(8'h56, 1'b1, 1'b1, 16'hFFFF);
        push_item(8'h78, 1'b1, 1'b1, 16'd0);
        push_item(8'h9A, 1'b1, 1'b0, 16'd4321);
        wait_drained();

        // Switch framing inside an open message; mode 0 keeps the check
        write_reg(REG_PACK_MODE, 8'(MODE_NONE));
        push_item(8'hBC, 1'b0, 1'b1, 16'd0);
        wait_drained();
        write_reg(REG_PACK_MODE, 8'(MODE_STX));
        push_item(8'hCD, 1'b0, 1'b1, 16'd0);
        wait_drained();

        // Random traffic: four idling patterns, two modes under each, so each mode runs twice
        for (p = 0; p < 8; p++) begin
            case (p / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            write_reg(REG_PACK_MODE, 8'(p % 4));
            write_reg(REG_START, 8'($urandom));
            write_reg(REG_END, 8'($urandom));
            write_reg(REG_ATTR, 8'($urandom));
            write_reg(REG_CMD, 8'($urandom));
            // Long receiver hold-off while the sender keeps offering
            if (p == 1) hold_armed = 1'b1;
            queue_traffic(20);
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        if (frame_expect.size() != 0)
            report_mismatch("framed bytes never delivered", frame_expect.size(), 0);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
